>>> src/s512_pkg.sv
// Shared types, constants and round functions for the SHA-512 hash engine.
// No dependencies; imported by s512_sched and sha512_hash_engine.
`default_nettype none

package s512_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned BLOCK_WDS  = 16;
    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned HASH_WDS   = 8;
    localparam logic [7:0]  PAD_LIMIT  = 8'd112;
    localparam logic [7:0]  BLOCK_BYTES = 8'd128;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [63:0] PAD_WORD   = {PAD_BYTE, 56'd0};

    localparam logic [63:0] IV [HASH_WDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } digest_item_t;

    // Commands from the sequencer to the message schedule window.
    typedef struct packed {
        logic        load_word;   // store one full word at pos
        logic        load_final;  // store last word, padding and maybe length
        logic        load_extra;  // load the extra length-only block
        logic        shift;       // advance schedule by one round
        logic        put_len;     // final block carries the length
        logic        mark80;      // extra block opens with the pad byte
        logic [3:0]  pos;
        logic [3:0]  vb;
        logic [63:0] word;
        logic [63:0] bit_len;
    } sched_cmd_t;

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        unique case (t)
            7'd0:  round_k = 64'h428a2f98d728ae22;
            7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538;
            7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b;
            7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242;
            7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c;
            7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f;
            7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235;
            7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2;
            7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5;
            7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275;
            7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
            7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab;
            7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f;
            7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2;
            7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f;
            7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc;
            7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed;
            7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de;
            7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6;
            7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364;
            7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791;
            7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218;
            7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a;
            7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8;
            7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99;
            7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63;
            7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373;
            7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc;
            7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72;
            7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28;
            7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915;
            7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c;
            7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e;
            7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba;
            7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae;
            7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84;
            7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc;
            7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6;
            7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec;
            7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = 64'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> src/sha512_hash_engine.sv
// SHA-512 hash engine top level: one round unit shared over 80 rounds.
// A word that does not complete a block is taken with no stall; a word that
// completes one stalls the input through the rounds and the fold. Last word:
// one or two blocks, then 8 digest beats, one per cycle while not stalled.
// Reset clears the sequencer, count and position and loads the initial hash words.
// Depends on s512_pkg and s512_sched.
`default_nettype none

module sha512_hash_engine import s512_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_stall,
    input  wire msg_item_t    msg,
    output logic              digest_valid,
    input  wire logic         digest_stall,
    output digest_item_t      digest
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] bit_cnt_reg, bit_cnt_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        final_reg, final_next;
    logic        extra_reg, extra_next;
    logic        mark80_reg, mark80_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic [63:0] chain_reg [HASH_WDS];
    logic [63:0] chain_next [HASH_WDS];
    logic [63:0] var_reg [HASH_WDS];
    logic [63:0] var_next [HASH_WDS];

    logic        accept;
    logic [3:0]  vb_c;
    logic [7:0]  off;
    logic [63:0] w_cur;
    logic [63:0] t1, t2;
    sched_cmd_t  cmd;

    s512_sched u_sched (
        .clk   (clk),
        .cmd   (cmd),
        .w_cur (w_cur)
    );

    assign accept = msg_valid && (state_reg == ST_IDLE);
    assign msg_stall = (state_reg != ST_IDLE);

    assign vb_c = (msg.valid_bytes > 4'd8) ? 4'd8 : msg.valid_bytes;
    assign off  = {1'b0, pos_reg, 3'd0} + {4'd0, vb_c};

    assign digest_valid        = (state_reg == ST_EMIT);
    assign digest.digest_word  = chain_reg[emit_idx_reg];
    assign digest.digest_index = emit_idx_reg;
    assign digest.digest_last  = (emit_idx_reg == 3'd7);

    // one compression round; var index 0..7 is a..h
    assign t1 = var_reg[7] + bsig1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + round_k(rnd_reg) + w_cur;
    assign t2 = bsig0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    always_comb
    begin
        cmd            = '0;
        cmd.pos        = pos_reg;
        cmd.vb         = vb_c;
        cmd.word       = msg.message_word;
        cmd.bit_len    = bit_cnt_next;
        cmd.mark80     = mark80_reg;
        cmd.put_len    = (off < PAD_LIMIT);
        cmd.load_word  = accept && !msg.end_of_message;
        cmd.load_final = accept && msg.end_of_message;
        cmd.load_extra = (state_reg == ST_FOLD) && extra_reg;
        cmd.shift      = (state_reg == ST_ROUND);
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        bit_cnt_next  = bit_cnt_reg;
        rnd_next      = rnd_reg;
        final_next    = final_reg;
        extra_next    = extra_reg;
        mark80_next   = mark80_reg;
        emit_idx_next = emit_idx_reg;
        chain_next    = chain_reg;
        var_next      = var_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!msg.end_of_message)
                    begin
                        bit_cnt_next = bit_cnt_reg + 64'd64;
                        pos_next     = pos_reg + 4'd1;
                        if (pos_reg == 4'd15)
                        begin
                            state_next = ST_ROUND;
                            rnd_next   = 7'd0;
                            var_next   = chain_reg;
                        end
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + {57'd0, vb_c, 3'd0};
                        pos_next     = 4'd0;
                        final_next   = 1'b1;
                        extra_next   = (off >= PAD_LIMIT);
                        mark80_next  = (off == BLOCK_BYTES);
                        state_next   = ST_ROUND;
                        rnd_next     = 7'd0;
                        var_next     = chain_reg;
                    end
                end
            end
            ST_ROUND:
            begin
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                rnd_next    = rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUNDS - 1))
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < HASH_WDS; i++)
                    chain_next[i] = chain_reg[i] + var_reg[i];
                priority if (extra_reg)
                begin
                    // length-only block; window is loaded this same cycle
                    extra_next = 1'b0;
                    state_next = ST_ROUND;
                    rnd_next   = 7'd0;
                    var_next   = chain_next;
                end
                else if (final_reg)
                begin
                    state_next    = ST_EMIT;
                    emit_idx_next = 3'd0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!digest_stall)
                begin
                    if (emit_idx_reg == 3'd7)
                    begin
                        state_next   = ST_IDLE;
                        final_next   = 1'b0;
                        bit_cnt_next = 64'd0;
                        pos_next     = 4'd0;
                        chain_next   = IV;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= 4'd0;
            bit_cnt_reg  <= 64'd0;
            rnd_reg      <= 7'd0;
            final_reg    <= 1'b0;
            extra_reg    <= 1'b0;
            mark80_reg   <= 1'b0;
            emit_idx_reg <= 3'd0;
            for (int i = 0; i < HASH_WDS; i++)
                chain_reg[i] <= IV[i];
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            bit_cnt_reg  <= bit_cnt_next;
            rnd_reg      <= rnd_next;
            final_reg    <= final_next;
            extra_reg    <= extra_next;
            mark80_reg   <= mark80_next;
            emit_idx_reg <= emit_idx_next;
            chain_reg    <= chain_next;
        end
    end

    // working variables a..h
    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
    end

endmodule

`default_nettype wire

>>> src/s512_sched.sv
// SHA-512 block buffer and message schedule: a 16-word window that is
// filled from input beats and shifts one word per round. Uses s512_pkg.
`default_nettype none

module s512_sched import s512_pkg::*;
(
    input  wire logic        clk,
    input  wire sched_cmd_t  cmd,
    output logic [63:0]      w_cur
);

    logic [63:0] win_reg  [BLOCK_WDS];
    logic [63:0] win_next [BLOCK_WDS];
    logic [63:0] new_w;
    logic [63:0] last_word;

    assign w_cur = win_reg[0];

    // W[t+16] from the window taps t, t+1, t+9, t+14
    assign new_w = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];

    // keep leading valid bytes, pad byte right after them, zeros beyond
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if (4'(j) < cmd.vb)
                last_word[63 - 8*j -: 8] = cmd.word[63 - 8*j -: 8];
            else if (4'(j) == cmd.vb)
                last_word[63 - 8*j -: 8] = PAD_BYTE;
            else
                last_word[63 - 8*j -: 8] = 8'd0;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        priority if (cmd.shift)
        begin
            for (int i = 0; i < BLOCK_WDS - 1; i++)
                win_next[i] = win_reg[i + 1];
            win_next[BLOCK_WDS - 1] = new_w;
        end
        else if (cmd.load_word)
        begin
            win_next[cmd.pos] = cmd.word;
        end
        else if (cmd.load_final)
        begin
            for (int i = 0; i < BLOCK_WDS; i++)
            begin
                if (4'(i) == cmd.pos)
                    win_next[i] = last_word;
                else if (({1'b0, cmd.pos} + 5'd1 == 5'(i)) && (cmd.vb == 4'd8))
                    win_next[i] = PAD_WORD;
                else if (4'(i) > cmd.pos)
                    win_next[i] = 64'd0;
            end
            if (cmd.put_len)
                win_next[BLOCK_WDS - 1] = cmd.bit_len;
        end
        else if (cmd.load_extra)
        begin
            for (int i = 0; i < BLOCK_WDS; i++)
                win_next[i] = 64'd0;
            win_next[0] = cmd.mark80 ? PAD_WORD : 64'd0;
            win_next[BLOCK_WDS - 1] = cmd.bit_len;
        end
        else
        begin
            win_next = win_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

>>> verif/sha512_hash_engine_tb.sv
// Self-checking testbench for sha512_hash_engine: random and directed messages with a
// built-in SHA-512 predictor checking every digest beat in order.
// Depends on s512_pkg for the beat types; needs only the RTL to build.

module sha512_hash_engine_tb import s512_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 220;
    localparam int IDLE_PCT     = 29;
    localparam int DRAIN_CYCLES = 200;

    localparam logic [63:0] ROUND_CONST [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] START_HASH [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] PAD_MARK = {8'h80, 56'd0};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    msg_item_t    msg = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    digest_item_t digest;

    // predictor state
    logic [63:0] blk_words [0:15];
    int unsigned fill_pos;
    logic [63:0] chain_h [0:7];
    logic [63:0] msg_bits;

    digest_item_t expected_digest_q [$];
    int           mismatches = 0;
    int           items_sent = 0;
    bit           calm = 1'b0;
    int           hold_req = 0;
    int           hold_left = 0;

    sha512_hash_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void chain_restart();
        for (int i = 0; i < 8; i++)
            chain_h[i] = START_HASH[i];
        for (int i = 0; i < 16; i++)
            blk_words[i] = '0;
        fill_pos = 0;
        msg_bits = '0;
    endfunction

    function automatic void sha_compress();
        logic [63:0] w [0:79];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = blk_words[t];
        for (int t = 16; t < 80; t++)
        begin
            s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
            s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int t = 0; t < 80; t++)
        begin
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[t] + w[t];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    // Takes one accepted beat; on the final word pads, finishes and queues the digest.
    function automatic void sha_absorb(input msg_item_t it);
        int unsigned vb;
        int unsigned pos;
        int unsigned off;
        logic [63:0] keep;
        digest_item_t d;
        vb = (it.valid_bytes > 4'd8) ? 8 : it.valid_bytes;
        pos = fill_pos;
        if (!it.end_of_message)
        begin
            blk_words[pos] = it.message_word;
            msg_bits += 64'd64;
            pos++;
            if (pos == 16)
            begin
                sha_compress();
                pos = 0;
            end
            fill_pos = pos;
            return;
        end
        msg_bits += 64'(vb * 8);
        off = pos * 8 + vb;
        if (vb < 8)
        begin
            keep = (vb == 0) ? 64'd0 : (~64'd0) << (64 - 8 * vb);
            blk_words[pos] = (it.message_word & keep) | (64'h80 << (56 - 8 * vb));
        end
        else
        begin
            blk_words[pos] = it.message_word;
            if (pos + 1 < 16)
                blk_words[pos+1] = PAD_MARK;
        end
        for (int i = pos + ((vb < 8) ? 1 : 2); i < 16; i++)
            blk_words[i] = '0;
        if (off < 112)
        begin
            blk_words[15] = msg_bits;
            sha_compress();
        end
        else
        begin
            // length does not fit: spill into an extra block
            sha_compress();
            for (int i = 0; i < 16; i++)
                blk_words[i] = '0;
            if (off == 128)
                blk_words[0] = PAD_MARK;
            blk_words[15] = msg_bits;
            sha_compress();
        end
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word  = chain_h[i];
            d.digest_index = 3'(i);
            d.digest_last  = (i == 7);
            expected_digest_q.push_back(d);
        end
        chain_restart();
    endfunction

    // receive side: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            digest_stall <= 1'b1;
        end
        else
            digest_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        digest_item_t exp_d;
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (expected_digest_q.size() == 0)
            begin
                $error("unexpected digest beat: word %h index %0d last %0b",
                       digest.digest_word, digest.digest_index, digest.digest_last);
                mismatches++;
            end
            else
            begin
                exp_d = expected_digest_q.pop_front();
                if (digest.digest_word !== exp_d.digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           exp_d.digest_word, digest.digest_word);
                    mismatches++;
                end
                if (digest.digest_index !== exp_d.digest_index)
                begin
                    $error("digest_index: expected %0d, got %0d",
                           exp_d.digest_index, digest.digest_index);
                    mismatches++;
                end
                if (digest.digest_last !== exp_d.digest_last)
                begin
                    $error("digest_last: expected %0b, got %0b",
                           exp_d.digest_last, digest.digest_last);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(input logic [63:0] word, input int vb, input bit eom);
        msg_item_t it;
        it.message_word   = word;
        it.valid_bytes    = 4'(vb);
        it.end_of_message = eom;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg <= it;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        sha_absorb(it);
        items_sent++;
    endtask

    // sender goes quiet so the last beat is not taken twice
    task automatic wait_drained();
        msg_valid <= 1'b0;
        while (expected_digest_q.size() != 0)
            @(posedge clk);
    endtask

    // Random message: mostly full words, sometimes odd valid_bytes on middle words.
    task automatic send_random_message(input int body_words);
        for (int i = 0; i < body_words; i++)
            send_word(rand64(), ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 8, 1'b0);
        send_word(rand64(),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                  1'b1);
    endtask

    function automatic int random_body_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 17);
    endfunction

    task automatic test_empty_message();
        send_word('1, 0, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_word('0, 8, 1'b0);
        send_word('1, 15, 1'b1);
    endtask

    task automatic test_partial_words();
        // short middle word still counts as eight bytes; garbage past the valid bytes dropped
        send_word(rand64(), 2, 1'b0);
        send_word('1, 5, 1'b1);
    endtask

    task automatic test_full_last_slot();
        for (int i = 0; i < 15; i++)
            send_word(rand64(), 8, 1'b0);
        send_word(rand64(), 8, 1'b1);
    endtask

    task automatic test_output_hold();
        hold_req = 600;
        for (int m = 0; m < 4; m++)
            send_random_message($urandom_range(0, 3));
        wait_drained();
    endtask

    task automatic test_pause_between();
        for (int m = 0; m < 3; m++)
        begin
            send_random_message($urandom_range(0, 18));
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        for (int m = 0; m < 4; m++)
            send_random_message($urandom_range(5, 16));
        wait_drained();
        calm = 1'b0;
    endtask

    task automatic test_random_messages(input int quota);
        int stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
            send_random_message(random_body_len());
    endtask

    initial
    begin
        chain_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_field_extremes();
        test_partial_words();
        test_full_last_slot();
        test_output_hold();
        test_pause_between();
        test_back_to_back();
        test_random_messages(RANDOM_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
